[sv/ckcb_pkg.sv]
// Shared types and constants for the color-keyed clipped blitter.
// Used by the top level and by its interface checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ckcb_pkg;

    // Configuration register indexes.
    typedef logic [2:0] cfg_idx_t;
    localparam cfg_idx_t REG_DEST_X        = 3'd0;
    localparam cfg_idx_t REG_DEST_Y        = 3'd1;
    localparam cfg_idx_t REG_RECT_WIDTH    = 3'd2;
    localparam cfg_idx_t REG_RECT_ROWS     = 3'd3;
    localparam cfg_idx_t REG_SCREEN_WIDTH  = 3'd4;
    localparam cfg_idx_t REG_SCREEN_HEIGHT = 3'd5;
    localparam cfg_idx_t REG_KEY_A         = 3'd6;
    localparam cfg_idx_t REG_KEY_B         = 3'd7;

    // Field and register widths.
    localparam int POS_W     = 10;
    localparam int SIZE_W    = 11;
    localparam int PIXEL_W   = 32;
    localparam int ADDR_W    = 20;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    // Stream widths: tdata padded to whole bytes.
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 56;
    localparam int M_PAD_W   = M_TDATA_W - ADDR_W - PIXEL_W;

    // Reset values of the configuration registers.
    localparam logic [SIZE_W-1:0] RECT_WIDTH_RST    = 11'd16;
    localparam logic [SIZE_W-1:0] RECT_ROWS_RST     = 11'd16;
    localparam logic [SIZE_W-1:0] SCREEN_WIDTH_RST  = 11'd320;
    localparam logic [SIZE_W-1:0] SCREEN_HEIGHT_RST = 11'd200;

endpackage

`default_nettype wire

[sv/color_key_clipped_blit.sv]
// Top level of the color-keyed blitter with destination clipping.
// Depends on ckcb_pkg for widths, register indexes and reset values.
//
// Usage:
//   The s_ channel carries one 32-bit source pixel per transfer, in raster
//   order over a rectangle of rect_width columns by rect_rows rows. For every
//   input transfer the m_ channel delivers exactly one result transfer:
//   m_tdata holds the linear destination address and the pixel, m_tuser is
//   the write enable and m_tlast marks the final pixel of the rectangle.
//   The write enable is high only when the destination position lies on the
//   screen and the pixel equals neither color key; address and pixel are
//   always given.
//   A pixel accepted on s_ appears on m_ in the next cycle. Throughput is
//   one pixel per cycle while the receiver does not stall, set by the single
//   output register stage; the address path is one 10 by 11 bit multiply and a
//   three-term add between the input port and that register.
//   When the receiver stalls, the result holds in the output register and
//   s_tready stays high only if that register is being drained in the same
//   cycle, so no result is lost or repeated.
//   Reset (aresetn low, synchronous) clears the column, row and row-base
//   counters, empties the output register and loads the register defaults:
//   origin 0,0, a 16 by 16 rectangle, a 320 by 200 screen and both keys 0.
//   Configuration writes take effect at the edge where cfg_we is high and
//   should only be issued while no pixel is in flight.
`timescale 1ns / 1ps
`default_nettype none

module color_key_clipped_blit #(
    parameter int COORD_BITS = 10
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    // Configuration write port.
    input  wire                                 cfg_we,
    input  wire [ckcb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire [ckcb_pkg::CFG_W-1:0]           cfg_wdata,
    // Source pixel stream.
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire [ckcb_pkg::S_TDATA_W-1:0]       s_tdata,   // [31:0] source_pixel
    // Destination write stream.
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [ckcb_pkg::M_TDATA_W-1:0]      m_tdata,   // [19:0] write_address,
                                                           // [51:20] write_pixel,
                                                           // [55:52] zero
    output logic                                m_tuser,   // [0] write_enable
    output logic                                m_tlast    // last_pixel
);

    // Size arithmetic has room for 2^COORD_BITS and for the 11-bit registers.
    localparam int SW = (COORD_BITS + 1 > ckcb_pkg::SIZE_W) ? COORD_BITS + 1
                                                            : ckcb_pkg::SIZE_W;
    // Destination coordinates: origin plus counter, never wrapping.
    localparam int XW = ((COORD_BITS > ckcb_pkg::POS_W) ? COORD_BITS
                                                        : ckcb_pkg::POS_W) + 1;
    // Width for comparing a coordinate against a screen dimension.
    localparam int CW = (XW > ckcb_pkg::SIZE_W) ? XW : ckcb_pkg::SIZE_W;
    localparam int PW = ckcb_pkg::POS_W + ckcb_pkg::SIZE_W;
    localparam logic [SW-1:0] COORD_MAX = SW'(1) << COORD_BITS;

    // Configuration registers.
    logic [ckcb_pkg::POS_W-1:0]   dest_x_reg;
    logic [ckcb_pkg::POS_W-1:0]   dest_y_reg;
    logic [ckcb_pkg::SIZE_W-1:0]  rect_width_reg;
    logic [ckcb_pkg::SIZE_W-1:0]  rect_rows_reg;
    logic [ckcb_pkg::SIZE_W-1:0]  screen_width_reg;
    logic [ckcb_pkg::SIZE_W-1:0]  screen_height_reg;
    logic [ckcb_pkg::PIXEL_W-1:0] key_a_reg;
    logic [ckcb_pkg::PIXEL_W-1:0] key_b_reg;

    // Raster position within the rectangle.
    logic [COORD_BITS-1:0]        col_reg, col_next;
    logic [COORD_BITS-1:0]        row_reg, row_next;
    logic [ckcb_pkg::ADDR_W-1:0]  row_base_reg, row_base_next;

    // Output register.
    logic                         m_valid_reg;
    logic                         we_reg, we_next;
    logic                         last_reg, last_next;
    logic [ckcb_pkg::ADDR_W-1:0]  addr_reg, addr_next;
    logic [ckcb_pkg::PIXEL_W-1:0] pixel_reg;

    logic [ckcb_pkg::PIXEL_W-1:0] pixel;
    logic                         accept;
    logic [SW-1:0]                width_ext, rows_ext;
    logic [SW-1:0]                col_last, row_last;
    logic                         end_col, end_row;
    logic [XW-1:0]                dst_x, dst_y;
    logic                         on_screen, keyed;
    logic [PW-1:0]                origin_offset;

    assign pixel    = s_tdata[ckcb_pkg::PIXEL_W-1:0];
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        // A size of zero acts as one, anything above 2^COORD_BITS as the maximum.
        width_ext = SW'(rect_width_reg);
        rows_ext  = SW'(rect_rows_reg);
        if (width_ext == '0) begin
            col_last = '0;
        end else if (width_ext > COORD_MAX) begin
            col_last = COORD_MAX - SW'(1);
        end else begin
            col_last = width_ext - SW'(1);
        end
        if (rows_ext == '0) begin
            row_last = '0;
        end else if (rows_ext > COORD_MAX) begin
            row_last = COORD_MAX - SW'(1);
        end else begin
            row_last = rows_ext - SW'(1);
        end
        // A counter at or beyond the last position wraps, which also covers
        // a size change in the middle of a rectangle.
        end_col = SW'(col_reg) >= col_last;
        end_row = SW'(row_reg) >= row_last;

        dst_x = XW'(dest_x_reg) + XW'(col_reg);
        dst_y = XW'(dest_y_reg) + XW'(row_reg);
        on_screen = (CW'(dst_x) < CW'(screen_width_reg))
                 && (CW'(dst_y) < CW'(screen_height_reg));
        keyed = (pixel == key_a_reg) || (pixel == key_b_reg);

        origin_offset = PW'(dest_y_reg) * PW'(screen_width_reg);
        addr_next = origin_offset[ckcb_pkg::ADDR_W-1:0] + row_base_reg
                  + ckcb_pkg::ADDR_W'(dst_x);
        we_next   = on_screen && !keyed;
        last_next = end_col && end_row;

        col_next      = col_reg + COORD_BITS'(1);
        row_next      = row_reg;
        row_base_next = row_base_reg;
        if (end_col) begin
            col_next = '0;
            if (end_row) begin
                row_next      = '0;
                row_base_next = '0;
            end else begin
                row_next      = row_reg + COORD_BITS'(1);
                row_base_next = row_base_reg + ckcb_pkg::ADDR_W'(screen_width_reg);
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dest_x_reg        <= '0;
            dest_y_reg        <= '0;
            rect_width_reg    <= ckcb_pkg::RECT_WIDTH_RST;
            rect_rows_reg     <= ckcb_pkg::RECT_ROWS_RST;
            screen_width_reg  <= ckcb_pkg::SCREEN_WIDTH_RST;
            screen_height_reg <= ckcb_pkg::SCREEN_HEIGHT_RST;
            key_a_reg         <= '0;
            key_b_reg         <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ckcb_pkg::REG_DEST_X:
                    dest_x_reg <= cfg_wdata[ckcb_pkg::POS_W-1:0];
                ckcb_pkg::REG_DEST_Y:
                    dest_y_reg <= cfg_wdata[ckcb_pkg::POS_W-1:0];
                ckcb_pkg::REG_RECT_WIDTH:
                    rect_width_reg <= cfg_wdata[ckcb_pkg::SIZE_W-1:0];
                ckcb_pkg::REG_RECT_ROWS:
                    rect_rows_reg <= cfg_wdata[ckcb_pkg::SIZE_W-1:0];
                ckcb_pkg::REG_SCREEN_WIDTH:
                    screen_width_reg <= cfg_wdata[ckcb_pkg::SIZE_W-1:0];
                ckcb_pkg::REG_SCREEN_HEIGHT:
                    screen_height_reg <= cfg_wdata[ckcb_pkg::SIZE_W-1:0];
                ckcb_pkg::REG_KEY_A:
                    key_a_reg <= cfg_wdata[ckcb_pkg::PIXEL_W-1:0];
                ckcb_pkg::REG_KEY_B:
                    key_b_reg <= cfg_wdata[ckcb_pkg::PIXEL_W-1:0];
            endcase
        end
    end

    // Counters and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            row_base_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                col_reg      <= col_next;
                row_reg      <= row_next;
                row_base_reg <= row_base_next;
                m_valid_reg  <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg  <= 1'b0;
            end
        end
    end

    // Output payload loads only on an accepted pixel, so it holds while stalled.
    always_ff @(posedge aclk) begin
        if (accept) begin
            we_reg    <= we_next;
            last_reg  <= last_next;
            addr_reg  <= addr_next;
            pixel_reg <= pixel;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {ckcb_pkg::M_PAD_W'(0), pixel_reg, addr_reg};
    assign m_tuser  = we_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

[sv/ckcb_checker.sv]
// Port-level checker for the color-keyed clipped blitter, with its bind.
// Depends on ckcb_pkg and on the color_key_clipped_blit port list.
`timescale 1ns / 1ps
`default_nettype none

module ckcb_checker (
    input wire                            aclk,
    input wire                            aresetn,
    input wire                            s_tvalid,
    input wire                            s_tready,
    input wire                            m_tvalid,
    input wire                            m_tready,
    input wire [ckcb_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire                            m_tuser,
    input wire                            m_tlast
);

    // An empty output register always leaves room for a new pixel.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with empty output register");

    // Every accepted pixel produces a result in the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted pixel produced no result");

    // A stalled result holds its contents.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("stalled result changed");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

endmodule

bind color_key_clipped_blit ckcb_checker u_ckcb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

[tb/tb_color_key_clipped_blit.sv]
// Self-checking testbench for the color-keyed clipped blitter: it streams source pixels,
// predicts every destination write with a behavioral model and checks each result transfer.
// Depends on ckcb_pkg and the color_key_clipped_blit top level.
`timescale 1ns / 1ps

module tb_color_key_clipped_blit;
    import ckcb_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int STALL_LIMIT   = 2000;   // cycles without any transfer or write
    localparam int RANDOM_PIXELS = 64;
    localparam int COORD_SPAN    = 1 << POS_W;

    // One predicted destination write, in the order the block delivers them.
    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  addr;
        logic [PIXEL_W-1:0] pixel;
        logic               last;
    } blit_write_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    cfg_idx_t             cfg_index = REG_DEST_X;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    // Shadow copy of the configuration registers, starting at their reset values.
    logic [POS_W-1:0]   dst_x  = '0;
    logic [POS_W-1:0]   dst_y  = '0;
    logic [SIZE_W-1:0]  rect_w = RECT_WIDTH_RST;
    logic [SIZE_W-1:0]  rect_h = RECT_ROWS_RST;
    logic [SIZE_W-1:0]  scr_w  = SCREEN_WIDTH_RST;
    logic [SIZE_W-1:0]  scr_h  = SCREEN_HEIGHT_RST;
    logic [PIXEL_W-1:0] key_a  = '0;
    logic [PIXEL_W-1:0] key_b  = '0;

    // Raster position inside the rectangle, cleared by reset.
    logic [POS_W-1:0]  col_pos  = '0;
    logic [POS_W-1:0]  row_pos  = '0;
    logic [ADDR_W-1:0] row_base = '0;

    blit_write_t expected_writes[$];
    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    int          rx_stall       = 0;
    bit          calm           = 1'b0;   // when set, neither side inserts gaps

    color_key_clipped_blit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // A size register of zero draws one pixel; anything past the counter span is capped.
    function automatic int unsigned size_clamp(logic [SIZE_W-1:0] v);
        if (v == 0) return 1;
        if (32'(v) > COORD_SPAN) return COORD_SPAN;
        return 32'(v);
    endfunction

    // Computes the write for one source pixel and advances the raster position.
    // Counters that sit past the last column or row (after the rectangle shrank)
    // behave as if they were on it, and the row base keeps what it has summed.
    function automatic blit_write_t predict_blit(logic [PIXEL_W-1:0] pix);
        blit_write_t w;
        int unsigned cols, rows, x, y;
        logic [31:0] sum;
        bit          end_col, end_row;
        cols    = size_clamp(rect_w);
        rows    = size_clamp(rect_h);
        x       = 32'(dst_x) + 32'(col_pos);
        y       = 32'(dst_y) + 32'(row_pos);
        sum     = 32'(dst_y) * 32'(scr_w) + 32'(row_base) + x;
        end_col = 32'(col_pos) >= cols - 1;
        end_row = 32'(row_pos) >= rows - 1;
        w.we    = (x < 32'(scr_w)) && (y < 32'(scr_h)) && (pix != key_a) && (pix != key_b);
        w.addr  = sum[ADDR_W-1:0];
        w.pixel = pix;
        w.last  = end_col && end_row;
        if (end_col) begin
            col_pos = '0;
            if (end_row) begin
                row_pos  = '0;
                row_base = '0;
            end else begin
                row_pos  = row_pos + POS_W'(1);
                row_base = row_base + ADDR_W'(scr_w);
            end
        end else begin
            col_pos = col_pos + POS_W'(1);
        end
        return w;
    endfunction

    // Presents one pixel after an optional gap and records its expected write
    // at the edge where the transfer happens.
    task automatic send_pixel(logic [PIXEL_W-1:0] pix);
        int gap;
        cfg_we <= 1'b0;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
        expected_writes.push_back(predict_blit(pix));
    endtask

    // Drops the source valid and waits until every expected write has come back.
    // Since each pixel yields exactly one write, an empty store means the block is idle.
    task automatic wait_idle();
        if (expected_writes.size() != 0) begin
            s_tvalid <= 1'b0;
            while (expected_writes.size() != 0) @(posedge aclk);
        end
    endtask

    // Writes one register. The unused upper bits of the bus carry random junk,
    // which the block has to ignore.
    task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
        logic [CFG_W-1:0] bus;
        bus = $urandom;
        case (idx)
            REG_DEST_X, REG_DEST_Y: bus[POS_W-1:0] = value[POS_W-1:0];
            REG_KEY_A, REG_KEY_B:   bus = value;
            default:                bus[SIZE_W-1:0] = value[SIZE_W-1:0];
        endcase
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= bus;
        @(posedge aclk);
        case (idx)
            REG_DEST_X:        dst_x  = bus[POS_W-1:0];
            REG_DEST_Y:        dst_y  = bus[POS_W-1:0];
            REG_RECT_WIDTH:    rect_w = bus[SIZE_W-1:0];
            REG_RECT_ROWS:     rect_h = bus[SIZE_W-1:0];
            REG_SCREEN_WIDTH:  scr_w  = bus[SIZE_W-1:0];
            REG_SCREEN_HEIGHT: scr_h  = bus[SIZE_W-1:0];
            REG_KEY_A:         key_a  = bus;
            REG_KEY_B:         key_b  = bus;
        endcase
    endtask

    // Each value travels at full bus width; write_reg keeps the register's bits.
    task automatic load_setting(logic [CFG_W-1:0] x0, logic [CFG_W-1:0] y0,
                                logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
                                logic [CFG_W-1:0] sw, logic [CFG_W-1:0] sh,
                                logic [CFG_W-1:0] ka, logic [CFG_W-1:0] kb);
        write_reg(REG_DEST_X, x0);
        write_reg(REG_DEST_Y, y0);
        write_reg(REG_RECT_WIDTH, w);
        write_reg(REG_RECT_ROWS, h);
        write_reg(REG_SCREEN_WIDTH, sw);
        write_reg(REG_SCREEN_HEIGHT, sh);
        write_reg(REG_KEY_A, ka);
        write_reg(REG_KEY_B, kb);
    endtask

    function automatic logic [POS_W-1:0] rand_pos();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return POS_W'($urandom_range(0, 15));
            default: return POS_W'($urandom_range(0, COORD_SPAN - 1));
        endcase
    endfunction

    // Mostly small rectangles so that whole frames fit in a phase; a few are
    // zero, full span or past the span.
    function automatic logic [SIZE_W-1:0] rand_size();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return SIZE_W'(1);
            2:       return SIZE_W'(COORD_SPAN);
            3:       return SIZE_W'($urandom_range(COORD_SPAN + 1, (1 << SIZE_W) - 1));
            default: return SIZE_W'($urandom_range(2, 8));
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] rand_screen();
        case ($urandom_range(0, 9))
            0:       return SIZE_W'(1);
            1:       return SIZE_W'(COORD_SPAN);
            2:       return SIZE_W'($urandom_range(0, (1 << SIZE_W) - 1));
            default: return SIZE_W'($urandom_range(16, COORD_SPAN));
        endcase
    endfunction

    function automatic logic [PIXEL_W-1:0] rand_key();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // A good share of pixels hit one of the keys so transparency is exercised.
    function automatic logic [PIXEL_W-1:0] rand_pixel();
        case ($urandom_range(0, 9))
            0:       return key_a;
            1:       return key_b;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Reset values: a 16 by 16 rectangle at the origin of a 320 by 200 screen,
    // both keys zero, so the zero pixel is transparent.
    task automatic test_reset_defaults();
        wait_idle();
        send_pixel('0);
        send_pixel('1);
        send_pixel(32'h0000_0001);
        send_pixel(32'h8000_0000);
    endtask

    // The rectangle shrinks while the counters sit past its new last column, so
    // they wrap at once. Later the screen width changes between rows and the row
    // base has to keep the old stride already summed.
    task automatic test_mid_rect_change();
        wait_idle();
        write_reg(REG_RECT_WIDTH, 2);
        write_reg(REG_RECT_ROWS, 2);
        write_reg(REG_SCREEN_WIDTH, 64);
        repeat (5) send_pixel($urandom);
        wait_idle();
        write_reg(REG_SCREEN_WIDTH, 100);
        repeat (2) send_pixel($urandom);
    endtask

    // Pixels equal to either key are not written; a near miss is.
    task automatic test_key_match();
        wait_idle();
        load_setting(0, 0, 4, 1, 320, 200, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        send_pixel(32'hA5A5_A5A5);
        send_pixel(32'h5A5A_5A5A);
        send_pixel(32'hA5A5_A5A4);
        send_pixel(32'hA5A5_A5A5);
    endtask

    // Placed at the far corner of a full-size screen, only the first pixel lands
    // on it, and the address runs past the 20-bit range and wraps. A 1 by 1 screen
    // then takes a single pixel.
    task automatic test_clip_and_wrap();
        wait_idle();
        load_setting('1, '1, 2, 2, COORD_SPAN, COORD_SPAN, 0, 0);
        repeat (4) send_pixel($urandom | 32'h1);
        wait_idle();
        load_setting(0, 0, 2, 1, 1, 1, 0, 0);
        repeat (2) send_pixel($urandom | 32'h1);
    endtask

    // Zero sizes act as one pixel. An oversize width stops at the counter span,
    // so the first row ends at column 1023 and the next pixel opens row 1; the
    // oversize row count must not end the frame there.
    task automatic test_size_clamp();
        wait_idle();
        load_setting(0, 0, 0, 0, 320, 200, 0, '1);
        repeat (2) send_pixel($urandom);
        wait_idle();
        load_setting(0, 0, '1, COORD_SPAN + 1, COORD_SPAN, COORD_SPAN, $urandom, $urandom);
        repeat (COORD_SPAN + 1) send_pixel(rand_pixel());
    endtask

    // Random phases. Each starts idle, rewrites some registers and then mostly
    // finishes the current frame plus up to two whole frames; the rest stop mid-frame
    // so the next setting lands with the counters part way through.
    task automatic test_random_traffic();
        int sent, n, rem, cols, rows, c, r;
        bit first;
        sent  = 0;
        first = 1'b1;
        while (sent < RANDOM_PIXELS) begin
            wait_idle();
            calm = ($urandom_range(0, 4) == 0);
            if (first || $urandom_range(0, 1) == 0)
                write_reg(REG_DEST_X, CFG_W'(rand_pos()));
            if (first || $urandom_range(0, 1) == 0)
                write_reg(REG_DEST_Y, CFG_W'(rand_pos()));
            if (first || $urandom_range(0, 1) == 0)
                write_reg(REG_RECT_WIDTH, CFG_W'(rand_size()));
            if (first || $urandom_range(0, 1) == 0)
                write_reg(REG_RECT_ROWS, CFG_W'(rand_size()));
            if (first || $urandom_range(0, 1) == 0)
                write_reg(REG_SCREEN_WIDTH, CFG_W'(rand_screen()));
            if (first || $urandom_range(0, 1) == 0)
                write_reg(REG_SCREEN_HEIGHT, CFG_W'(rand_screen()));
            if (first || $urandom_range(0, 1) == 0) write_reg(REG_KEY_A, rand_key());
            if (first || $urandom_range(0, 1) == 0) write_reg(REG_KEY_B, rand_key());
            first = 1'b0;
            // Pixels left until the current frame ends, with out-of-range
            // counters treated as sitting on the last column or row.
            cols = size_clamp(rect_w);
            rows = size_clamp(rect_h);
            c    = (int'(col_pos) < cols) ? int'(col_pos) : cols - 1;
            r    = (int'(row_pos) < rows) ? int'(row_pos) : rows - 1;
            rem  = (rows - 1 - r) * cols + (cols - 1 - c) + 1;
            if (rem + cols * rows <= 200 && $urandom_range(0, 4) != 0)
                n = rem + cols * rows * $urandom_range(0, 2);
            else
                n = $urandom_range(1, 40);
            repeat (n) send_pixel(rand_pixel());
            sent += n;
        end
        calm = 1'b0;
    endtask

    task automatic finish_run();
        wait_idle();
        repeat (3) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_mid_rect_change();
        test_key_match();
        test_clip_and_wrap();
        test_size_clamp();
        test_random_traffic();
        finish_run();
    end

    // Receiver: holds tready low for random stretches unless the phase is calm.
    always @(posedge aclk) begin
        if (rx_stall == 0 && !calm && $urandom_range(0, 4) == 0) rx_stall = pick_gap();
        if (rx_stall > 0) begin
            m_tready <= 1'b0;
            rx_stall--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Every result transfer is matched against the oldest expected write.
    always @(posedge aclk) begin : check_writes
        blit_write_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_writes.size() == 0) begin
                $error("result transfer with no pixel pending, write_address %0h",
                       m_tdata[ADDR_W-1:0]);
                mismatch_count++;
            end else begin
                want = expected_writes.pop_front();
                if (m_tdata[ADDR_W-1:0] !== want.addr) begin
                    $error("write_address: expected %0h, got %0h",
                           want.addr, m_tdata[ADDR_W-1:0]);
                    mismatch_count++;
                end
                if (m_tdata[ADDR_W +: PIXEL_W] !== want.pixel) begin
                    $error("write_pixel: expected %0h, got %0h",
                           want.pixel, m_tdata[ADDR_W +: PIXEL_W]);
                    mismatch_count++;
                end
                if (m_tdata[M_TDATA_W-1 -: M_PAD_W] !== '0) begin
                    $error("tdata padding: expected 0, got %0h",
                           m_tdata[M_TDATA_W-1 -: M_PAD_W]);
                    mismatch_count++;
                end
                if (m_tuser !== want.we) begin
                    $error("write_enable: expected %0b, got %0b", want.we, m_tuser);
                    mismatch_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_pixel: expected %0b, got %0b", want.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: a long run of cycles with no transfer on either side and no
    // register write means the block has hung.
    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles++;
        end
    end

endmodule
